[rtl/mfse_pkg.sv]
package mfse_pkg;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_RECT  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_UNSUP  = 2'd1,
    ST_DROP   = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_READ,
    S_WRITE,
    S_FIN
  } state_e;

  localparam logic [7:0] BYTE_ALL_OFF = 8'hFF;
  localparam logic [7:0] BYTE_ALL_ON  = 8'h00;

  typedef struct packed {
    logic clear;     // clearing pass write
    logic load;      // capture a new item
    logic calc;      // register address of the current element
    logic step;      // write back and advance
    logic out_load;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty;
    logic last;
  } stat_t;

endpackage

[rtl/mfse_ctrl.sv]
module mfse_ctrl import mfse_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_busy_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        if (stat_i.empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.step = 1'b1;
        state_d    = stat_i.last ? S_FIN : S_CALC;
      end
      S_FIN: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/mfse_datapath.sv]
module mfse_datapath import mfse_pkg::*; #(
  parameter int BYTES_PER_LINE = 32,
  parameter int DISPLAY_LINES  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output stat_t      stat_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] area_x_i,
  input  logic [5:0] area_y_i,
  input  logic [7:0] area_width_i,
  input  logic [5:0] area_height_i,
  input  logic [7:0] x_start_i,
  input  logic [5:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [5:0] y_end_i,
  input  logic [7:0] color_i,
  input  logic [8:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] read_data_o,
  output logic [1:0] status_o
);

  localparam int STORE_BYTES = BYTES_PER_LINE * DISPLAY_LINES;
  localparam int MEM_AW      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int EA_BASE     = 8 + $clog2(BYTES_PER_LINE + 1) + 1;
  localparam int EA_W        = (EA_BASE > MEM_AW + 1) ? EA_BASE : MEM_AW + 1;

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  logic [MEM_AW-1:0] clr_cnt_q;

  mode_e      mode_q;
  logic       on_q, chk_q, unsup_q, drop_q;
  logic [7:0] bx_q, aw_q, res_q;
  logic [5:0] by_q, ah_q;
  logic [9:0] rx0_q, rx_q;
  logic [8:0] ncol_q, ccnt_q;
  logic [7:0] ry_q;
  logic [6:0] rcnt_q;

  logic [MEM_AW-1:0] addr_q;
  logic              inr_q, pass_q, byte_q;
  logic [2:0]        bit_q;

  // item setup
  logic       ld_unsup, ld_on, ld_chk;
  logic [6:0] ld_rows;
  logic [8:0] ld_ncol;
  logic [7:0] ld_bx;
  logic [5:0] ld_by;

  always_comb begin
    ld_unsup = 1'b0;
    ld_rows  = 7'd1;
    ld_ncol  = 9'd1;
    ld_chk   = 1'b1;
    ld_bx    = area_x_i;
    ld_by    = area_y_i;
    ld_on    = (color_i != 8'd0);
    case (mode_e'(mode_i))
      MODE_PIXEL: ;
      MODE_LINE: begin
        if (x_start_i == x_end_i) begin
          if (y_start_i > y_end_i) begin
            ld_unsup = 1'b1;
            ld_rows  = 7'd0;
          end else begin
            ld_rows = {1'b0, y_end_i} - {1'b0, y_start_i} + 7'd1;
          end
        end else if (y_start_i == y_end_i) begin
          if (x_start_i > x_end_i) begin
            ld_unsup = 1'b1;
            ld_rows  = 7'd0;
          end else begin
            ld_ncol = {1'b0, x_end_i} - {1'b0, x_start_i} + 9'd1;
          end
        end else begin
          ld_unsup = 1'b1;
          ld_rows  = 7'd0;
        end
      end
      MODE_RECT: begin
        ld_ncol = rect_width_i;
        ld_rows = rect_height_i;
        ld_chk  = 1'b0;
        ld_bx   = 8'd0;
        ld_by   = 6'd0;
        ld_on   = 1'b0;
      end
      MODE_READ: begin
        ld_chk = 1'b0;
        ld_bx  = 8'd0;
        ld_by  = 6'd0;
      end
      default: ;
    endcase
  end

  // element address
  logic [9:0]      dx;
  logic [7:0]      dy;
  logic [EA_W-1:0] ea;
  logic            is_read;
  logic            byte_el;

  assign is_read = (mode_q == MODE_READ);
  assign dx = 10'(bx_q) + rx_q;
  assign dy = 8'(by_q) + ry_q;
  assign ea = EA_W'(dy) * EA_W'(BYTES_PER_LINE) + EA_W'(dx[9:3]);
  // whole bytes skip the area bounds check
  assign byte_el = (dx[2:0] == 3'd0) && (ccnt_q >= 9'd8) && !is_read;

  // write back
  logic [7:0] mask, wdata;
  logic       do_wr, col_end;
  logic [8:0] adv;

  assign mask    = 8'd1 << bit_q;
  assign do_wr   = cmd_i.step && !is_read && pass_q && inr_q;
  assign adv     = byte_q ? 9'd8 : 9'd1;
  assign col_end = (ccnt_q == adv);

  always_comb begin
    if (byte_q) wdata = on_q ? BYTE_ALL_ON : BYTE_ALL_OFF;
    else if (on_q) wdata = rdata_q & ~mask;
    else wdata = rdata_q | mask;
  end

  assign stat_o.clear_last = (32'(clr_cnt_q) == 32'(STORE_BYTES - 1));
  assign stat_o.empty      = (rcnt_q == 7'd0) || (ncol_q == 9'd0);
  assign stat_o.last       = col_end && (rcnt_q == 7'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_cnt_q] <= BYTE_ALL_OFF;
    end else if (do_wr) begin
      mem_q[addr_q] <= wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      on_q    <= ld_on;
      chk_q   <= ld_chk;
      unsup_q <= ld_unsup;
      drop_q  <= 1'b0;
      res_q   <= 8'd0;
      bx_q    <= ld_bx;
      by_q    <= ld_by;
      aw_q    <= area_width_i;
      ah_q    <= area_height_i;
      rx0_q   <= 10'(x_start_i);
      rx_q    <= 10'(x_start_i);
      ry_q    <= 8'(y_start_i);
      ncol_q  <= ld_ncol;
      ccnt_q  <= ld_ncol;
      rcnt_q  <= ld_rows;
    end
    if (cmd_i.calc) begin
      addr_q <= ea[MEM_AW-1:0];
      inr_q  <= (32'(ea) < 32'(STORE_BYTES));
      pass_q <= !chk_q || byte_el || ((rx_q <= 10'(aw_q)) && (ry_q <= 8'(ah_q)));
      byte_q <= byte_el;
      bit_q  <= dx[2:0];
    end
    if (cmd_i.step) begin
      if (is_read) begin
        if (inr_q) res_q <= rdata_q;
        else drop_q <= 1'b1;
      end else if (pass_q && !inr_q) begin
        drop_q <= 1'b1;
      end
      if (col_end) begin
        rx_q   <= rx0_q;
        ccnt_q <= ncol_q;
        ry_q   <= ry_q + 8'd1;
        rcnt_q <= rcnt_q - 7'd1;
      end else begin
        rx_q   <= rx_q + 10'(adv);
        ccnt_q <= ccnt_q - adv;
      end
    end
    if (cmd_i.out_load) begin
      read_data_o <= res_q;
      status_o    <= drop_q ? ST_DROP : (unsup_q ? ST_UNSUP : ST_DONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule

[rtl/mono_framebuffer_span_engine_core.sv]
// Flow: after accept, each pixel or whole byte touched passes through the CALC,
// READ and WRITE states; an item that touches nothing goes from CALC to FIN.
// Throughput: one item at a time; each pixel or byte drawn is a read-modify-write
// through the single-port frame store; the next item can be taken the cycle after
// the result register loads, which waits while the output is stalled.
// Reset: a clearing pass fills all BYTES_PER_LINE * DISPLAY_LINES store bytes
// with 0xFF before the first item is taken.
module mono_framebuffer_span_engine_core import mfse_pkg::*; #(
  parameter int BYTES_PER_LINE = 32,
  parameter int DISPLAY_LINES  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] area_x_i,
  input  logic [5:0] area_y_i,
  input  logic [7:0] area_width_i,
  input  logic [5:0] area_height_i,
  input  logic [7:0] x_start_i,
  input  logic [5:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [5:0] y_end_i,
  input  logic [7:0] color_i,
  input  logic [8:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [1:0] status_o
);

  cmd_t  cmd;
  stat_t stat;

  mfse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_valid_o && out_stall_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  mfse_datapath #(
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .DISPLAY_LINES  (DISPLAY_LINES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .area_x_i      (area_x_i),
    .area_y_i      (area_y_i),
    .area_width_i  (area_width_i),
    .area_height_i (area_height_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .color_i       (color_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .read_data_o   (read_data_o),
    .status_o      (status_o)
  );

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_UNUSED))
    else $error("invalid status code");

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (read_data_o == 8'd0))
    else $error("read data with failing status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item in progress");
`endif

endmodule
